@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every clock edge outside reset.
`define SRTF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("srtf assertion failed");

// When cond holds, require res at the next clock edge.
`define SRTF_ASSERT_NEXT(lbl, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("srtf assertion failed");

`endif

@@ rtl/srtf_pkg.sv @@
// ---------------------------------------------------------------------------
// srtf_pkg
// Shared constants, types and state codes of the SRTF scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IN_SLOT_W = 4;
    localparam int TIME_W    = 16;
    localparam int TICK_W    = 32;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remain;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // Control from the sequencer to the selector
    typedef struct packed {
        logic              start;
        logic              ent_valid;
        logic [SLOT_W-1:0] idx;
    } scan_ctl_t;

    // Best candidate seen so far in a scan
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        entry_t            entry;
    } best_t;

endpackage

`default_nettype wire

@@ rtl/srtf_ram.sv @@
// ---------------------------------------------------------------------------
// srtf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/srtf_sel.sv @@
// ---------------------------------------------------------------------------
// srtf_sel
// Running minimum over the slot entries streamed out of the slot memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srtf_sel (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire srtf_pkg::scan_ctl_t           ctl,
    input  wire srtf_pkg::entry_t              ent,
    input  wire logic [srtf_pkg::TICK_W-1:0]   tick,
    output srtf_pkg::best_t                    best
);

    srtf_pkg::best_t best_reg;
    logic            take;

    // Ready, has work, and strictly shorter: ties keep the lower slot
    always_comb
    begin
        take = ctl.ent_valid
            && ({{(srtf_pkg::TICK_W-srtf_pkg::TIME_W){1'b0}}, ent.arrival} <= tick)
            && (ent.remain != '0)
            && (!best_reg.found || (ent.remain < best_reg.entry.remain));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (ctl.start)
        begin
            best_reg.found <= 1'b0;
        end
        else if (take)
        begin
            best_reg.found <= 1'b1;
            best_reg.idx   <= ctl.idx;
            best_reg.entry <= ent;
        end
    end

    assign best = best_reg;

    `SRTF_ASSERT(a_best_has_work, best_reg.found |-> (best_reg.entry.remain != '0))
    `SRTF_ASSERT_NEXT(a_start_clears, ctl.start, !best_reg.found)
    `SRTF_ASSERT_NEXT(a_take_found, take && !ctl.start, best_reg.found)

endmodule

`default_nettype wire

@@ rtl/srtf_preemptive_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// srtf_preemptive_scheduler_core
// Preemptive shortest-remaining-time-first scheduler over a slot memory.
// ---------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_stall | op, slot, arrival_time, burst_time
//   output  | out_valid/out_stall | ran_slot, idle, finished, waiting_time,
//           |                     | turnaround_time
//
// A load item writes the slot memory straight away. A tick item scans
// the slot memory one entry per cycle through its single read port, then
// passes through a drain state, a write-back state and a result state.
// Reset clears the tick counter and the per-slot valid bits at once; a slot
// whose valid bit is clear reads as all zeros, so no clearing pass is needed.
// A stalled result holds in the output register; the sequencer waits in its
// result state until the register is free, and the input stalls meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srtf_preemptive_scheduler_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic [srtf_pkg::IN_SLOT_W-1:0]     slot,
    input  wire logic [srtf_pkg::TIME_W-1:0]        arrival_time,
    input  wire logic [srtf_pkg::TIME_W-1:0]        burst_time,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [3:0]                              ran_slot,
    output logic                                    idle,
    output logic                                    finished,
    output logic [31:0]                             waiting_time,
    output logic [31:0]                             turnaround_time
);

    localparam logic [srtf_pkg::SLOT_W-1:0] LAST_SLOT =
        srtf_pkg::SLOT_W'(srtf_pkg::NUM_SLOTS - 1);

    // Sequencer state
    srtf_pkg::state_t state_reg;
    srtf_pkg::state_t state_next;

    // Scan address, read pipeline tag and per-slot valid bits
    logic [srtf_pkg::SLOT_W-1:0]    cnt_reg;
    logic                           rd_pend_reg;
    logic                           rd_valid_reg;
    logic [srtf_pkg::SLOT_W-1:0]    rd_idx_reg;
    logic [srtf_pkg::NUM_SLOTS-1:0] valid_reg;

    // Time keeping
    logic [srtf_pkg::TICK_W-1:0]    tick_reg;
    logic [srtf_pkg::TICK_W-1:0]    tick_inc;
    logic [srtf_pkg::TICK_W-1:0]    tat_reg;

    // Output register
    logic                           out_valid_reg;
    logic [3:0]                     ran_slot_reg;
    logic                           idle_reg;
    logic                           finished_reg;
    logic [31:0]                    waiting_reg;
    logic [31:0]                    turnaround_reg;

    // Sequencer outputs
    logic                           in_fire;
    logic                           load_fire;
    logic                           tick_fire;
    logic                           slot_ok;
    logic                           scan_issue;
    logic                           wb_phase;
    logic                           out_load;

    // Memory port signals
    logic                           ram_we;
    logic [srtf_pkg::SLOT_W-1:0]    ram_waddr;
    srtf_pkg::entry_t               ram_wdata;
    logic [srtf_pkg::SLOT_W-1:0]    ld_addr;
    logic [srtf_pkg::ENT_W-1:0]     ram_q;
    srtf_pkg::entry_t               rd_ent;

    srtf_pkg::scan_ctl_t            sel_ctl;
    srtf_pkg::best_t                best;

    logic [srtf_pkg::TICK_W-1:0]    burst_ext;
    logic [srtf_pkg::TICK_W-1:0]    wait_val;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (in_valid && (op == srtf_pkg::OP_TICK))
                begin
                    state_next = srtf_pkg::ST_SCAN;
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = srtf_pkg::ST_DRAIN;
                end
            end
            srtf_pkg::ST_DRAIN:  state_next = srtf_pkg::ST_WRITE;
            srtf_pkg::ST_WRITE:  state_next = srtf_pkg::ST_RESULT;
            srtf_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            default:             state_next = srtf_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_stall   = 1'b1;
        scan_issue = 1'b0;
        wb_phase   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:   in_stall   = 1'b0;
            srtf_pkg::ST_SCAN:   scan_issue = 1'b1;
            srtf_pkg::ST_DRAIN:  ;
            srtf_pkg::ST_WRITE:  wb_phase   = 1'b1;
            srtf_pkg::ST_RESULT: out_load   = !out_valid_reg || !out_stall;
            default:             ;
        endcase
    end

    // Load items beyond the slot range are dropped
    assign slot_ok   = 32'(slot) < srtf_pkg::NUM_SLOTS;
    assign ld_addr   = srtf_pkg::SLOT_W'(slot);
    assign in_fire   = in_valid && !in_stall;
    assign load_fire = in_fire && (op == srtf_pkg::OP_LOAD) && slot_ok;
    assign tick_fire = in_fire && (op == srtf_pkg::OP_TICK);

    // ---------------------------------------------------------------
    // Slot memory: loads write from the ports, write-back stores the
    // decremented remaining time of the chosen slot
    // ---------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ld_addr;
        ram_wdata.arrival = arrival_time;
        ram_wdata.burst   = burst_time;
        ram_wdata.remain  = burst_time;
        if (load_fire)
        begin
            ram_we = 1'b1;
        end
        else if (wb_phase && best.found)
        begin
            ram_we           = 1'b1;
            ram_waddr        = best.idx;
            ram_wdata        = best.entry;
            ram_wdata.remain = best.entry.remain - 1'b1;
        end
    end

    srtf_ram #(
        .WIDTH (srtf_pkg::ENT_W),
        .DEPTH (srtf_pkg::NUM_SLOTS),
        .AW    (srtf_pkg::SLOT_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (scan_issue),
        .raddr (cnt_reg),
        .q     (ram_q)
    );

    // A slot never loaded since reset reads as empty
    assign rd_ent = rd_valid_reg ? srtf_pkg::entry_t'(ram_q) : '0;

    assign sel_ctl.start     = tick_fire;
    assign sel_ctl.ent_valid = rd_pend_reg;
    assign sel_ctl.idx       = rd_idx_reg;

    srtf_sel u_sel (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sel_ctl),
        .ent   (rd_ent),
        .tick  (tick_reg),
        .best  (best)
    );

    // Saturating tick advance
    assign tick_inc = (tick_reg == srtf_pkg::TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    // Waiting time: turnaround minus burst, clamped at zero
    assign burst_ext = srtf_pkg::TICK_W'(best.entry.burst);
    assign wait_val  = (tat_reg >= burst_ext) ? tat_reg - burst_ext : '0;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            valid_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= scan_issue;

            // Advance the scan address; restart it on each tick item
            if (tick_fire)
            begin
                cnt_reg <= '0;
            end
            else if (scan_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (scan_issue)
            begin
                rd_valid_reg <= valid_reg[cnt_reg];
            end

            if (load_fire)
            begin
                valid_reg[ld_addr] <= 1'b1;
            end

            // Time advances on every tick, idle or not
            if (wb_phase)
            begin
                tick_reg <= tick_inc;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            rd_idx_reg <= cnt_reg;
        end

        // Finish time is the counter after this tick
        if (wb_phase)
        begin
            tat_reg <= tick_inc - srtf_pkg::TICK_W'(best.entry.arrival);
        end

        if (out_load)
        begin
            ran_slot_reg <= best.found ? 4'(best.idx) : 4'd0;
            idle_reg     <= !best.found;
            if (best.found && (best.entry.remain == srtf_pkg::TIME_W'(1)))
            begin
                finished_reg   <= 1'b1;
                waiting_reg    <= wait_val;
                turnaround_reg <= tat_reg;
            end
            else
            begin
                finished_reg   <= 1'b0;
                waiting_reg    <= '0;
                turnaround_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign ran_slot        = ran_slot_reg;
    assign idle            = idle_reg;
    assign finished        = finished_reg;
    assign waiting_time    = waiting_reg;
    assign turnaround_time = turnaround_reg;

    `SRTF_ASSERT(a_wr_phase,
        ram_we |-> ((state_reg == srtf_pkg::ST_IDLE) || (state_reg == srtf_pkg::ST_WRITE)))
    `SRTF_ASSERT_NEXT(a_result_lands, out_load, out_valid_reg)
    `SRTF_ASSERT_NEXT(a_tick_sat, tick_reg == srtf_pkg::TICK_MAX, tick_reg == srtf_pkg::TICK_MAX)
    `SRTF_ASSERT_NEXT(a_drain_last, state_reg == srtf_pkg::ST_DRAIN, !rd_pend_reg)

endmodule

`default_nettype wire

@@ test/srtf_preemptive_scheduler_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srtf_preemptive_scheduler_core_tb
// Self-checking bench for the SRTF scheduler core. A scoreboard keeps its
// own copy of the slot stores and tick counter and predicts the result of
// every accepted tick item. A short directed sequence covers ties, reloads,
// preemption, empty and never-arriving slots. Random load/tick episodes with
// bursty input and a patterned output stall follow.
// ---------------------------------------------------------------------------

typedef struct packed {
    logic [3:0]  ran_slot;
    logic        idle;
    logic        finished;
    logic [31:0] waiting_time;
    logic [31:0] turnaround_time;
} sched_result_t;

class sched_scoreboard;
    logic [15:0]   arrival_mem [srtf_pkg::NUM_SLOTS];
    logic [15:0]   burst_mem   [srtf_pkg::NUM_SLOTS];
    logic [15:0]   remain_mem  [srtf_pkg::NUM_SLOTS];
    logic [31:0]   tick_now;
    sched_result_t pending_q [$];
    int            errors;
    int            loads;
    int            ticks;
    int            checked;
    int            completions;
    int            idles;

    function new();
        for (int k = 0; k < srtf_pkg::NUM_SLOTS; k++)
        begin
            arrival_mem[k] = '0;
            burst_mem[k]   = '0;
            remain_mem[k]  = '0;
        end
        tick_now    = '0;
        errors      = 0;
        loads       = 0;
        ticks       = 0;
        checked     = 0;
        completions = 0;
        idles       = 0;
    endfunction

    function void step_tick();
        if (tick_now != srtf_pkg::TICK_MAX)
            tick_now = tick_now + 1;
    endfunction

    // Note one accepted input item and queue the result it causes.
    function void note_item(input logic o, input logic [3:0] s,
                            input logic [15:0] a, input logic [15:0] b);
        sched_result_t exp_r;
        bit            found;
        int            best;
        logic [15:0]   best_rem;
        longint        fin;
        longint        wt;
        longint        tat;
        found    = 0;
        best     = 0;
        best_rem = '0;
        exp_r    = '0;
        if (o == srtf_pkg::OP_LOAD)
        begin
            loads++;
            if (int'(s) < srtf_pkg::NUM_SLOTS)
            begin
                arrival_mem[s] = a;
                burst_mem[s]   = b;
                remain_mem[s]  = b;
            end
            return;
        end
        ticks++;
        for (int k = 0; k < srtf_pkg::NUM_SLOTS; k++)
        begin
            if ({16'h0, arrival_mem[k]} <= tick_now && remain_mem[k] != 0 &&
                (!found || remain_mem[k] < best_rem))
            begin
                found    = 1;
                best     = k;
                best_rem = remain_mem[k];
            end
        end
        if (!found)
        begin
            step_tick();
            exp_r.idle = 1'b1;
        end
        else
        begin
            remain_mem[best] = remain_mem[best] - 16'd1;
            step_tick();
            exp_r.ran_slot = best[3:0];
            if (remain_mem[best] == 0)
            begin
                fin = tick_now;
                wt  = fin - longint'(burst_mem[best]) - longint'(arrival_mem[best]);
                tat = fin - longint'(arrival_mem[best]);
                if (wt < 0)
                    wt = 0;
                if (tat < 0)
                    tat = 0;
                exp_r.finished        = 1'b1;
                exp_r.waiting_time    = wt[31:0];
                exp_r.turnaround_time = tat[31:0];
            end
        end
        pending_q.push_back(exp_r);
    endfunction

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Check one accepted result against the oldest prediction.
    function void check_result(input sched_result_t got);
        sched_result_t exp_r;
        if (pending_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected: expected none, actual slot %0d idle %0d",
                     $time, got.ran_slot, got.idle);
            return;
        end
        exp_r = pending_q.pop_front();
        checked++;
        if (exp_r.finished)
            completions++;
        if (exp_r.idle)
            idles++;
        compare_field("ran_slot", exp_r.ran_slot, got.ran_slot);
        compare_field("idle", exp_r.idle, got.idle);
        compare_field("finished", exp_r.finished, got.finished);
        compare_field("waiting_time", exp_r.waiting_time, got.waiting_time);
        compare_field("turnaround_time", exp_r.turnaround_time, got.turnaround_time);
    endfunction

    function int pending();
        return pending_q.size();
    endfunction
endclass

module srtf_preemptive_scheduler_core_tb;

    localparam int TOTAL_ITEMS  = 1450;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 48;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = srtf_pkg::OP_LOAD;
    logic [3:0]  slot = '0;
    logic [15:0] arrival_time = '0;
    logic [15:0] burst_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  ran_slot;
    logic        idle;
    logic        finished;
    logic [31:0] waiting_time;
    logic [31:0] turnaround_time;

    // Toggled by the stimulus to ask the receiver for one long hold-off
    logic        hold_req = 1'b0;

    sched_scoreboard sb;
    int          items_sent = 0;
    int          ticks_offered = 0;
    int          burst_left = 0;
    longint      cycle_count = 0;

    always #4 clk = ~clk;

    srtf_preemptive_scheduler_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .slot            (slot),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ran_slot        (ran_slot),
        .idle            (idle),
        .finished        (finished),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time)
    );

    // -----------------------------------------------------------------------
    // Monitor: sample both handshakes at the clock edge. All bench drives are
    // nonblocking, so the values seen here are those settled before the edge.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(op, slot, arrival_time, burst_time);
            if (out_valid && !out_stall)
                sb.check_result('{ran_slot, idle, finished, waiting_time,
                                   turnaround_time});
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often. A toggle
    // of hold_req starts one long hold-off, counted here, so that the result
    // register stays full and the input backs up.
    // -----------------------------------------------------------------------
    int   rx_cycle = 0;
    int   rx_mode = 0;
    int   hold_left = 0;
    logic hold_seen = 1'b0;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if the traffic never drains.
    // -----------------------------------------------------------------------
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("srtf_preemptive_scheduler_core_tb failed");
        $finish;
    end

    // Offer one item and hold it until accepted; then pace the burst, dropping
    // valid for a random gap once the current burst is used up.
    task automatic offer_item(input logic o, input logic [3:0] s,
                              input logic [15:0] a, input logic [15:0] b);
        int gap;
        in_valid     <= 1'b1;
        op           <= o;
        slot         <= s;
        arrival_time <= a;
        burst_time   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (o == srtf_pkg::OP_TICK)
            ticks_offered++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // Occasionally run a long stretch with no idling at all
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 10);
            gap = $urandom_range(1, 25);
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic offer_load(input logic [3:0] s, input logic [15:0] a,
                              input logic [15:0] b);
        offer_item(srtf_pkg::OP_LOAD, s, a, b);
    endtask

    // Tick items carry random junk in the unused fields.
    task automatic offer_tick();
        offer_item(srtf_pkg::OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Pick an arrival near the tick counter so that most loads become ready.
    function automatic logic [15:0] pick_arrival();
        int r;
        int back;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'($urandom);
        if (r < 4)
            return 16'(ticks_offered + $urandom_range(1, 8));
        back = (ticks_offered < 4) ? ticks_offered : 4;
        return 16'(ticks_offered - $urandom_range(0, back));
    endfunction

    // Mostly short bursts so that processes finish; now and then empty or huge.
    function automatic logic [15:0] pick_burst();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'($urandom);
        return 16'($urandom_range(1, 8));
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        int  n_loads;
        int  n_ticks;
        int  pick;
        bit  hold_done;
        hold_done  = 0;
        sb         = new();
        burst_left = $urandom_range(1, 10);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Tick straight after reset: all slots empty, so idle.
        offer_tick();
        // One-tick process that completes at once
        offer_load(4'd0, 16'h0000, 16'h0001);
        offer_tick();
        // Slot that never arrives, at the top of both fields
        offer_load(4'd15, 16'hFFFF, 16'hFFFF);
        // Equal remaining time: the lower slot must win
        offer_load(4'd5, 16'h0000, 16'h0003);
        offer_load(4'd3, 16'h0000, 16'h0003);
        offer_tick();
        offer_tick();
        // Reload the running slot: all three stores are replaced
        offer_load(4'd3, 16'h0001, 16'h0002);
        // Zero burst leaves the slot empty
        offer_load(4'd7, 16'h0000, 16'h0000);
        offer_tick();
        // A newcomer tying on remaining time with a lower index preempts
        offer_load(4'd1, 16'h0000, 16'h0001);
        offer_tick();
        offer_tick();
        repeat (3)
            offer_tick();
        // Nothing left: idle tick still advances time
        offer_tick();
        // Arrival in the future: idle until it comes due
        offer_load(4'd10, 16'(ticks_offered + 1), 16'h0002);
        offer_tick();
        offer_tick();
        offer_tick();
        // Clear the never-arriving slot again
        offer_load(4'd15, 16'h0000, 16'h0000);

        // Random part: mostly well-formed load-then-tick episodes, some noise.
        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                    offer_item(1'($urandom), 4'($urandom), 16'($urandom),
                               16'($urandom));
            end
            else
            begin
                n_loads = $urandom_range(1, 5);
                n_ticks = $urandom_range(1, 14);
                repeat (n_loads)
                    offer_load(4'($urandom), pick_arrival(), pick_burst());
                repeat (n_ticks)
                    offer_tick();
            end
            // Halfway through, ask for the long receiver hold-off
            if (!hold_done && items_sent > TOTAL_ITEMS / 2)
            begin
                hold_req <= ~hold_req;
                hold_done = 1;
            end
        end

        // Drain: wait for every predicted result, then a little longer so
        // that any stray result still shows up.
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d items: %0d loads and %0d ticks over %0d cycles.",
                 items_sent, sb.loads, sb.ticks, cycle_count);
        $display("Checked %0d results: %0d completions, %0d idle ticks, %0d errors.",
                 sb.checked, sb.completions, sb.idles, sb.errors);
        if (sb.errors == 0)
            $display("srtf_preemptive_scheduler_core_tb passed");
        else
            $display("srtf_preemptive_scheduler_core_tb failed");
        $finish;
    end

endmodule
